// ----- hw/rtl/sha1_message_hasher_assert.svh -----
// Assertion macros used by the checker file of the SHA-1 hasher.
// Depends on nothing; include by bare file name.
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// check a property on every clock edge outside reset
`define SHA1M_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sha1m: %s failed", "name");

// check that a condition never holds outside reset
`define SHA1M_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sha1m: %s failed", "name");

`endif

// ----- hw/rtl/sha1m_pkg.sv -----
// Shared types and constants of the SHA-1 message hasher.
// No dependencies.
package sha1m_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] hash_t;

  typedef struct packed {
    logic shift_byte;
    logic shift_word;
  } cell_ctl_t;

  localparam int unsigned NumCells = 16;

  localparam hash_t Sha1Iv = '{
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] PadStop   = 6'd56;
  localparam logic [2:0] LastIdx   = 3'd4;
  localparam logic [2:0] LenLast   = 3'd7;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

// ----- hw/rtl/sha1m_cell.sv -----
// One 32-bit cell of the block buffer and message schedule line.
// Depends on sha1m_pkg.
module sha1m_cell (
  input  logic                 clk_i,
  input  sha1m_pkg::cell_ctl_t ctl_i,
  input  sha1m_pkg::word_t     nxt_i,
  output sha1m_pkg::word_t     word_o
);
  import sha1m_pkg::*;

  word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.shift_word) begin
      word_d = nxt_i;
    end else if (ctl_i.shift_byte) begin
      word_d = {word_q[23:0], nxt_i[31:24]};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- hw/rtl/sha1m_round.sv -----
// One SHA-1 compression round on the five working words.
// Depends on sha1m_pkg.
module sha1m_round (
  input  sha1m_pkg::hash_t  work_i,
  input  sha1m_pkg::word_t  w_i,
  input  logic [6:0]        round_i,
  output sha1m_pkg::hash_t  work_o
);
  import sha1m_pkg::*;

  word_t f, k, t;

  always_comb begin
    if (round_i < 7'd20) begin
      f = (work_i[1] & work_i[2]) | (~work_i[1] & work_i[3]);
      k = K0;
    end else if (round_i < 7'd40) begin
      f = work_i[1] ^ work_i[2] ^ work_i[3];
      k = K1;
    end else if (round_i < 7'd60) begin
      f = (work_i[1] & work_i[2]) | (work_i[1] & work_i[3]) | (work_i[2] & work_i[3]);
      k = K2;
    end else begin
      f = work_i[1] ^ work_i[2] ^ work_i[3];
      k = K3;
    end
    t = rotl(work_i[0], 5) + f + work_i[4] + k + w_i;
    work_o[0] = t;
    work_o[1] = work_i[0];
    work_o[2] = rotl(work_i[1], 30);
    work_o[3] = work_i[2];
    work_o[4] = work_i[3];
  end

endmodule

// ----- hw/rtl/sha1_message_hasher.sv -----
// SHA-1 hasher: data bytes are taken while loading; the byte that fills a block is followed
// by the compression rounds, one round per cycle, and one chaining add, and no new byte is
// taken until they are done.
// End of message: padding bytes, one or two compressions, then five digest words, one per
// cycle while m_axis_tready is high. Async reset loads the initial vector at once.
module sha1_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha1m_pkg::*;

  typedef enum logic [2:0] {S_LOAD, S_PAD, S_COMP, S_FIN, S_OUT} state_e;

  state_e     state_q, state_d;
  hash_t      chain_q, chain_d;
  hash_t      work_q, work_d;
  hash_t      round_out;
  logic [63:0] bits_q, bits_d;
  logic [5:0] fill_q, fill_d;
  logic [6:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] lcnt_q, lcnt_d;
  logic       first_q, first_d;
  logic       lenph_q, lenph_d;
  logic       pad_q, pad_d;
  logic       done_q, done_d;

  logic       push_en;
  logic [7:0] push_byte;
  cell_ctl_t  ctl;
  word_t      words [NumCells];
  word_t      nxt   [NumCells];
  word_t      sched_new;
  word_t      out_word;

  assign sched_new = rotl(words[13] ^ words[8] ^ words[2] ^ words[0], 1);

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    if (g == NumCells - 1) begin : g_tail
      assign nxt[g] = ctl.shift_word ? sched_new : {push_byte, 24'h000000};
    end else begin : g_body
      assign nxt[g] = words[g + 1];
    end
    sha1m_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .nxt_i  (nxt[g]),
      .word_o (words[g])
    );
  end

  sha1m_round u_round (
    .work_i  (work_q),
    .w_i     (words[0]),
    .round_i (round_q),
    .work_o  (round_out)
  );

  always_comb begin
    state_d   = state_q;
    chain_d   = chain_q;
    work_d    = work_q;
    bits_d    = bits_q;
    fill_d    = fill_q;
    round_d   = round_q;
    idx_d     = idx_q;
    lcnt_d    = lcnt_q;
    first_d   = first_q;
    lenph_d   = lenph_q;
    pad_d     = pad_q;
    done_d    = done_q;
    push_en   = 1'b0;
    push_byte = 8'h00;
    ctl       = '0;

    case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid) begin
          if (s_axis_tlast) begin
            state_d = S_PAD;
            first_d = 1'b1;
            lenph_d = 1'b0;
            lcnt_d  = 3'd0;
            pad_d   = 1'b1;
            done_d  = 1'b0;
          end else begin
            push_en   = 1'b1;
            push_byte = s_axis_tdata;
            bits_d    = bits_q + 64'd8;
          end
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        if (first_q) begin
          push_byte = PadMark;
          first_d   = 1'b0;
        end else if (lenph_q || fill_q == PadStop) begin
          push_byte = bits_q[63:56];
          bits_d    = {bits_q[55:0], 8'h00};
          lenph_d   = 1'b1;
          lcnt_d    = lcnt_q + 3'd1;
          if (lcnt_q == LenLast) begin
            done_d = 1'b1;
          end
        end
      end
      S_COMP: begin
        ctl.shift_word = 1'b1;
        work_d  = round_out;
        round_d = round_q + 7'd1;
        if (round_q == RoundLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        for (int i = 0; i < 5; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        if (done_q) begin
          state_d = S_OUT;
        end else if (pad_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastIdx) begin
            idx_d   = 3'd0;
            chain_d = Sha1Iv;
            bits_d  = '0;
            pad_d   = 1'b0;
            done_d  = 1'b0;
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    if (push_en) begin
      ctl.shift_byte = 1'b1;
      fill_d = fill_q + 6'd1;
      if (&fill_q) begin
        state_d = S_COMP;
        work_d  = chain_q;
        round_d = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      chain_q <= Sha1Iv;
      bits_q  <= '0;
      fill_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
      lcnt_q  <= '0;
      first_q <= 1'b0;
      lenph_q <= 1'b0;
      pad_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      bits_q  <= bits_d;
      fill_q  <= fill_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      lcnt_q  <= lcnt_d;
      first_q <= first_d;
      lenph_q <= lenph_d;
      pad_q   <= pad_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_comb begin
    case (idx_q)
      3'd0:    out_word = chain_q[0];
      3'd1:    out_word = chain_q[1];
      3'd2:    out_word = chain_q[2];
      3'd3:    out_word = chain_q[3];
      default: out_word = chain_q[4];
    endcase
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'b00000, idx_q, out_word};
  assign m_axis_tlast  = (idx_q == LastIdx);

endmodule

// ----- hw/rtl/sha1m_checker.sv -----
// Port-level checks of the SHA-1 hasher, bound to the top level.
// Depends on sha1_message_hasher_assert.svh.
`include "sha1_message_hasher_assert.svh"

module sha1m_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `SHA1M_ASSERT(a_last_index, clk_i, rst_ni, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[34:32] == 3'd4))
  `SHA1M_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready && m_axis_tvalid)
  `SHA1M_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  `SHA1M_ASSERT(a_resume, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
  `SHA1M_ASSERT(a_eom_stall, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)

endmodule

bind sha1_message_hasher sha1m_checker u_sha1m_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
